FILE: src/fpc_pkg.sv
// Shared constants, types and a helper function for the framed packet parser.
`timescale 1ns / 1ps
package fpc_pkg;

  // Default packet store depth and register reset value.
  localparam int unsigned BUF_DEPTH_DEF = 20;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  // Configuration port geometry and register index.
  localparam int unsigned PADDR_W      = 3;
  localparam logic        REG_TIMEOUT  = 1'b0;

  // Request kinds.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_DATA    = 2'd0;
  localparam logic [1:0] STATUS_CSUM    = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  // Framing characters.
  localparam logic [7:0] START_MARK = 8'h21;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_Q = 8'h51;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_C = 8'h43;

  // Packet lengths by type letter.
  localparam int unsigned LEN_SENSOR = 15;
  localparam int unsigned LEN_QUAT   = 19;
  localparam int unsigned LEN_BUTTON = 5;
  localparam int unsigned LEN_COLOR  = 6;

  // Command and status bundles between controller and datapath.
  typedef struct packed {
    logic accept;
    logic load_err;
    logic load_tmo;
    logic emit_rd;
    logic emit_load;
  } fpc_cmd_t;

  typedef struct packed {
    logic pkt_ok;
    logic pkt_bad;
    logic tmo_hit;
    logic out_free;
    logic emit_last;
  } fpc_sts_t;

  // Expected packet length from the type letter; unknown letters fill the store.
  function automatic int unsigned length_for_type(logic [7:0] t, int unsigned depth);
    int unsigned len;
    case (t)
      CH_A, CH_G, CH_M, CH_L, CH_S: len = LEN_SENSOR;
      CH_Q:                         len = LEN_QUAT;
      CH_B:                         len = LEN_BUTTON;
      CH_C:                         len = LEN_COLOR;
      default:                      len = depth;
    endcase
    return len;
  endfunction

endpackage

FILE: src/fpc_ctrl.sv
// Controller state machine: request acceptance and packet emission sequencing.
`timescale 1ns / 1ps
module fpc_ctrl
  import fpc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fpc_sts_t sts_i,
  output fpc_cmd_t cmd_o
);

  localparam logic [1:0] S_COLLECT = 2'd0;
  localparam logic [1:0] S_READ    = 2'd1;
  localparam logic [1:0] S_LOAD    = 2'd2;

  logic [1:0] state_q, state_d;

  // Requests are taken while collecting and the output register can take a result.
  assign in_ready_o = (state_q == S_COLLECT) && sts_i.out_free;

  // Next state and commands.
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.accept    = in_valid_i && in_ready_o;
    cmd_o.load_err  = cmd_o.accept && sts_i.pkt_bad;
    cmd_o.load_tmo  = cmd_o.accept && sts_i.tmo_hit;
    case (state_q)
      S_COLLECT: begin
        if (cmd_o.accept && sts_i.pkt_ok) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = S_LOAD;
      end
      S_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d         = sts_i.emit_last ? S_COLLECT : S_READ;
        end
      end
      default: begin
        state_d = S_COLLECT;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/fpc_datapath.sv
// Datapath: packet store, framing counters, checksum, timeout and output register.
`timescale 1ns / 1ps
module fpc_datapath
  import fpc_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fpc_cmd_t    cmd_i,
  output fpc_sts_t    sts_o,
  input  logic        req_type_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic [15:0] timeout_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [1:0]  status_o,
  output logic [7:0]  data_byte_o,
  output logic [4:0]  byte_index_o,
  output logic        last_o
);

  localparam int unsigned FILL_W = $clog2(BUF_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(BUF_DEPTH);

  // Packet store.
  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rdata_q;

  // Framing state.
  logic              in_pkt_q;
  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] exp_q;
  logic [7:0]        sum_q;
  logic [15:0]       idle_q;
  logic [15:0]       tmo_q;
  logic [FILL_W-1:0] emit_n_q;
  logic [ADDR_W-1:0] emit_idx_q;

  // Output register.
  logic       out_valid_q;
  logic [1:0] status_q;
  logic [7:0] data_q;
  logic [4:0] index_q;
  logic       last_q;

  logic              is_byte, is_start, overflow, complete, csum_ok;
  logic [FILL_W-1:0] fill_inc, exp_eff;
  logic [15:0]       idle_inc;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              load_any;

  // Decode of the request against the current framing state.
  assign is_byte  = (req_type_i == REQ_BYTE);
  assign is_start = is_byte && (rx_byte_i == START_MARK);
  assign overflow = (fill_q >= FILL_W'(BUF_DEPTH));
  assign fill_inc = fill_q + FILL_W'(1);
  assign exp_eff  = (fill_q == FILL_W'(1)) ?
                    FILL_W'(length_for_type(rx_byte_i, BUF_DEPTH)) : exp_q;
  assign complete = is_byte && !is_start && in_pkt_q && !overflow && (fill_inc >= exp_eff);
  assign csum_ok  = (~sum_q == rx_byte_i);
  assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;

  assign load_any = cmd_i.load_err || cmd_i.load_tmo || cmd_i.emit_load;

  assign sts_o.pkt_ok    = complete && csum_ok;
  assign sts_o.pkt_bad   = complete && !csum_ok;
  assign sts_o.tmo_hit   = !is_byte && in_pkt_q && (idle_inc >= tmo_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.emit_last = ((FILL_W'(emit_idx_q) + FILL_W'(1)) == emit_n_q);

  // Store write: a start mark lands at index zero, other packet bytes at the fill index.
  assign mem_we    = cmd_i.accept && is_byte && (is_start || (in_pkt_q && !overflow));
  assign mem_waddr = is_start ? '0 : fill_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_rd) begin
      rdata_q <= mem[emit_idx_q];
    end
  end

  // Framing state update on each accepted request, and emission index advance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q   <= 1'b0;
      fill_q     <= '0;
      exp_q      <= FILL_W'(BUF_DEPTH);
      sum_q      <= '0;
      idle_q     <= '0;
      emit_n_q   <= '0;
      emit_idx_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        if (!is_byte) begin
          if (in_pkt_q) begin
            if (sts_o.tmo_hit) begin
              in_pkt_q <= 1'b0;
              fill_q   <= '0;
              exp_q    <= FILL_W'(BUF_DEPTH);
              sum_q    <= '0;
              idle_q   <= '0;
            end else begin
              idle_q <= idle_inc;
            end
          end
        end else if (is_start) begin
          in_pkt_q <= 1'b1;
          fill_q   <= FILL_W'(1);
          exp_q    <= FILL_W'(BUF_DEPTH);
          sum_q    <= rx_byte_i;
          idle_q   <= '0;
        end else if (in_pkt_q) begin
          if (overflow || complete) begin
            in_pkt_q <= 1'b0;
            fill_q   <= '0;
            exp_q    <= FILL_W'(BUF_DEPTH);
            sum_q    <= '0;
            idle_q   <= '0;
            if (complete) begin
              emit_n_q   <= fill_inc;
              emit_idx_q <= '0;
            end
          end else begin
            fill_q <= fill_inc;
            exp_q  <= exp_eff;
            sum_q  <= 8'(sum_q + rx_byte_i);
            idle_q <= '0;
          end
        end
      end else if (cmd_i.emit_load && !sts_o.emit_last) begin
        emit_idx_q <= emit_idx_q + ADDR_W'(1);
      end
    end
  end

  // Timeout register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      tmo_q <= cfg_wdata_i;
    end
  end

  assign timeout_o = tmo_q;

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_any) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      status_q <= STATUS_DATA;
      data_q   <= rdata_q;
      index_q  <= emit_idx_q[4:0];
      last_q   <= sts_o.emit_last;
    end else if (cmd_i.load_err) begin
      status_q <= STATUS_CSUM;
      data_q   <= '0;
      index_q  <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.load_tmo) begin
      status_q <= STATUS_TIMEOUT;
      data_q   <= '0;
      index_q  <= '0;
      last_q   <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign data_byte_o  = data_q;
  assign byte_index_o = index_q;
  assign last_o       = last_q;

endmodule

FILE: src/framed_packet_parser_checksum.sv
// Top level of the framed packet parser with inverted-sum checksum.
`timescale 1ns / 1ps
// Each request is a received byte or a millisecond tick. Bytes collect in
// a packet store from a '!' start mark; the type letter in the second byte
// sets the packet length. A completed packet whose last byte equals the
// inverted 8-bit sum of the others is emitted one result per byte: the
// store is read, then the output register is loaded once it is free, and
// new requests are held off until the last byte is loaded. A checksum
// mismatch or a timeout gives one result, loaded as the request is taken.
// The timeout register sits at byte address 0 of the APB port.
module framed_packet_parser_checksum
  import fpc_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [7:0]         rx_byte_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [7:0]         data_byte_o,
  output logic [4:0]         byte_index_o,
  output logic               last_o,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  fpc_cmd_t    cmd;
  fpc_sts_t    sts;
  logic        cfg_we;
  logic [15:0] timeout;

  // Register decode.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT);
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout} : 32'd0;

  fpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fpc_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_type_i),
    .rx_byte_i    (rx_byte_i),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (pwdata[15:0]),
    .timeout_o    (timeout),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .data_byte_o  (data_byte_o),
    .byte_index_o (byte_index_o),
    .last_o       (last_o)
  );

endmodule

FILE: tb/framed_packet_parser_checksum_tb.sv
// Testbench for the framed packet parser: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module framed_packet_parser_checksum_tb;
  import fpc_pkg::*;

  localparam int unsigned DEPTH        = BUF_DEPTH_DEF;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = PADDR_W'(4 * int'(REG_TIMEOUT));

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
  } rx_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic [4:0] index;
    logic       last;
  } parse_result_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic               req_type_i   = REQ_BYTE;
  logic [7:0]         rx_byte_i    = 8'h00;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [1:0]         status_o;
  logic [7:0]         data_byte_o;
  logic [4:0]         byte_index_o;
  logic               last_o;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [PADDR_W-1:0] paddr        = '0;
  logic [31:0]        pwdata       = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Stimulus and expectation stores.
  rx_req_t       pending_reqs[$];
  parse_result_t expected_results[$];
  rx_req_t       next_req;
  parse_result_t got_result;
  parse_result_t want_result;
  int unsigned   item_count     = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles  = 0;
  logic          no_gaps       = 1'b0;

  // Predictor state: a copy of the packet store, framing state and timeout register.
  logic [7:0]  frame_buf [DEPTH];
  int unsigned fill_cnt;
  logic        in_frame;
  int unsigned frame_len;
  logic [7:0]  byte_sum;
  int unsigned idle_ticks;
  logic [15:0] timeout_cfg;

  framed_packet_parser_checksum #(
    .BUF_DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .data_byte_o (data_byte_o),
    .byte_index_o(byte_index_o),
    .last_o      (last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Length of a packet as set by its type letter.
  function automatic int unsigned frame_length(input logic [7:0] letter);
    case (letter)
      CH_A, CH_G, CH_M, CH_L, CH_S: return LEN_SENSOR;
      CH_Q:                         return LEN_QUAT;
      CH_B:                         return LEN_BUTTON;
      CH_C:                         return LEN_COLOR;
      default:                      return DEPTH;
    endcase
  endfunction

  function automatic parse_result_t make_result(input logic [1:0] status,
                                                input logic [7:0] data,
                                                input logic [4:0] index,
                                                input logic last);
    parse_result_t r;
    r.status = status;
    r.data   = data;
    r.index  = index;
    r.last   = last;
    return r;
  endfunction

  // Return the predictor to waiting for a start mark.
  task automatic clear_frame();
    in_frame   = 1'b0;
    fill_cnt   = 0;
    frame_len  = DEPTH;
    byte_sum   = 8'h00;
    idle_ticks = 0;
  endtask

  // Work out the results of one accepted request.
  task automatic parse_step(input logic kind, input logic [7:0] value);
    if (kind == REQ_TICK) begin
      if (in_frame) begin
        if (idle_ticks < 65535) idle_ticks++;
        if (idle_ticks >= timeout_cfg) begin
          clear_frame();
          expected_results.push_back(make_result(STATUS_TIMEOUT, 8'h00, 5'd0, 1'b1));
        end
      end
    end else if (value == START_MARK) begin
      frame_buf[0] = value;
      fill_cnt     = 1;
      in_frame     = 1'b1;
      frame_len    = DEPTH;
      byte_sum     = value;
      idle_ticks   = 0;
    end else if (in_frame) begin
      idle_ticks = 0;
      frame_buf[fill_cnt] = value;
      fill_cnt++;
      if (fill_cnt == 2) frame_len = frame_length(value);
      if (fill_cnt >= frame_len) begin
        // The last byte must be the inverted sum of all the others.
        if (~byte_sum == value) begin
          for (int unsigned i = 0; i < fill_cnt; i++) begin
            expected_results.push_back(make_result(STATUS_DATA, frame_buf[i], 5'(i),
                                                   (i + 1 == fill_cnt)));
          end
        end else begin
          expected_results.push_back(make_result(STATUS_CSUM, 8'h00, 5'd0, 1'b1));
        end
        clear_frame();
      end else begin
        byte_sum = byte_sum + value;
      end
    end
  endtask

  task automatic push_req(input logic kind, input logic [7:0] value);
    rx_req_t r;
    r.kind  = kind;
    r.value = value;
    pending_reqs.push_back(r);
    item_count++;
  endtask

  // Random byte that never looks like a start mark.
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == START_MARK) b = ~b;
    return b;
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] known [8];
    known = '{CH_A, CH_G, CH_M, CH_L, CH_S, CH_Q, CH_B, CH_C};
    if ($urandom_range(8) == 0) return body_byte();
    return known[$urandom_range(7)];
  endfunction

  // Queue one whole packet, with optional idle ticks between its bytes.
  task automatic push_frame(input logic [7:0] letter, input logic good,
                            input int unsigned gap_ticks);
    int unsigned len;
    logic [7:0]  sum;
    logic [7:0]  b;
    len = frame_length(letter);
    push_req(REQ_BYTE, START_MARK);
    push_req(REQ_BYTE, letter);
    sum = START_MARK + letter;
    for (int unsigned i = 2; i + 1 < len; i++) begin
      if (gap_ticks > 0 && $urandom_range(3) == 0) begin
        repeat ($urandom_range(1, gap_ticks)) push_req(REQ_TICK, 8'($urandom));
      end
      b = body_byte();
      push_req(REQ_BYTE, b);
      sum = sum + b;
    end
    b = ~sum;
    if (!good) b = b ^ 8'($urandom_range(1, 255));
    push_req(REQ_BYTE, b);
  endtask

  // Mostly well-formed packets; the rest are broken packets, noise and raw requests.
  task automatic push_random(input int unsigned budget);
    int unsigned goal;
    int unsigned pick;
    int unsigned gap;
    int unsigned n;
    goal = item_count + budget;
    gap  = (timeout_cfg > 1) ? ((timeout_cfg > 8) ? 8 : timeout_cfg - 1) : 0;
    while (item_count < goal) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        push_frame(pick_letter(), $urandom_range(9) != 0, gap);
      end else if (pick < 80) begin
        // Packet cut short (unless its type is short), left open or run into the timeout.
        n = $urandom_range(1, 12);
        push_req(REQ_BYTE, START_MARK);
        push_req(REQ_BYTE, pick_letter());
        repeat (n - 1) push_req(REQ_BYTE, body_byte());
        if (timeout_cfg <= 16 && $urandom_range(1) == 1) begin
          repeat ((timeout_cfg == 0) ? 1 : timeout_cfg) push_req(REQ_TICK, 8'($urandom));
        end
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) push_req(1'($urandom_range(1)), body_byte());
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          push_req(($urandom_range(3) == 0) ? REQ_TICK : REQ_BYTE,
                   ($urandom_range(7) == 0) ? START_MARK : 8'($urandom));
        end
      end
    end
  endtask

  // Register write over the configuration port: setup cycle, then access cycle.
  task automatic write_timeout(input logic [15:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TIMEOUT_ADDR;
    pwdata  <= {16'h0000, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    timeout_cfg = v;
  endtask

  // Wait until every request is taken and every expected result has come back.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Request driver: presents queued requests and predicts taken ones; random gaps unless no_gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) parse_step(req_type_i, rx_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(99) >= 21)) begin
          next_req = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= next_req.kind;
          rx_byte_i  <= next_req.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each result with the oldest expectation and drives out_ready_i.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_result = make_result(status_o, data_byte_o, byte_index_o, last_o);
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("unexpected result: status %0d data %02h index %0d last %0b",
                     status_o, data_byte_o, byte_index_o, last_o);
          end
          mismatch_count++;
        end else begin
          want_result = expected_results.pop_front();
          if (got_result.status !== want_result.status || got_result.data !== want_result.data
              || got_result.index !== want_result.index
              || got_result.last !== want_result.last) begin
            if (mismatch_count < 10) begin
              $display("result mismatch: expected status %0d data %02h index %0d last %0b,",
                       want_result.status, want_result.data, want_result.index,
                       want_result.last);
              $display("  got status %0d data %02h index %0d last %0b",
                       got_result.status, got_result.data, got_result.index, got_result.last);
            end
            mismatch_count++;
          end
        end
      end
      out_ready_i <= no_gaps || ($urandom_range(99) >= 21);
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[framed_packet_parser_checksum] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_frame();
    timeout_cfg = TIMEOUT_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: stray bytes and a tick while waiting, good and bad packets, restarts.
    push_req(REQ_BYTE, 8'h00);
    push_req(REQ_BYTE, 8'hFF);
    push_req(REQ_TICK, 8'hA5);
    push_frame(CH_B, 1'b1, 0);
    push_frame(CH_C, 1'b0, 0);
    // A start mark in the checksum position restarts the packet.
    push_req(REQ_BYTE, START_MARK);
    push_req(REQ_BYTE, CH_B);
    push_req(REQ_BYTE, 8'h5A);
    push_req(REQ_BYTE, 8'hC3);
    push_req(REQ_BYTE, START_MARK);
    // A start mark in the middle of a packet restarts it too.
    push_req(REQ_BYTE, CH_C);
    push_req(REQ_BYTE, 8'h10);
    push_frame(CH_B, 1'b1, 0);
    push_random(20);
    drain();

    // Smallest timeouts: the first idle tick in a packet drops it.
    write_timeout(16'd1);
    push_random(15);
    drain();
    write_timeout(16'd0);
    push_random(10);
    drain();

    // Short timeout with ticks between bytes, and no idling on either side.
    no_gaps <= 1'b1;
    write_timeout(16'($urandom_range(2, 12)));
    push_random(30);
    drain();
    no_gaps <= 1'b0;

    // Largest timeout: a packet survives idle gaps and an open packet outlasts a run of ticks.
    write_timeout(16'hFFFF);
    push_frame(CH_S, 1'b1, 8);
    push_req(REQ_BYTE, START_MARK);
    push_req(REQ_BYTE, CH_Q);
    push_req(REQ_BYTE, body_byte());
    repeat (12) push_req(REQ_TICK, 8'($urandom));
    push_random(10);
    drain();

    write_timeout(16'($urandom_range(1, 65535)));
    push_random(15);
    drain();

    if (expected_results.size() != 0) mismatch_count += expected_results.size();
    if (mismatch_count == 0) begin
      $display("[framed_packet_parser_checksum] OK");
    end else begin
      $display("[framed_packet_parser_checksum] ERROR");
    end
    $finish;
  end

endmodule

FILE: framed_packet_parser_checksum.f
src/fpc_pkg.sv
src/fpc_ctrl.sv
src/fpc_datapath.sv
src/framed_packet_parser_checksum.sv
tb/framed_packet_parser_checksum_tb.sv
